/* rtl/bvs_pkg.sv */
// Shared types and constants for the battery voltage smoother.
// No dependencies; imported by the front end, back end, top level and testbench.
package bvs_pkg;

  // Field widths
  localparam int ADC_W   = 12;
  localparam int MV_W    = 13;
  localparam int PCT_W   = 7;
  localparam int DB_W    = 10;
  localparam int WT_W    = 4;
  localparam int CFG_W   = 13;
  localparam int CFG_A_W = 2;

  // Conversion constants
  localparam int ADC_MAX       = 4095;
  localparam int FULL_SCALE_MV = 6600;
  localparam int PCT_FULL      = 100;
  localparam int WT_FULL       = 10;

  // Block defaults
  localparam int SAMPLES_DEF = 10;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WEIGHT   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_EMPTY    = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_FULL     = 2'd3;

  // Register reset values
  localparam logic [DB_W-1:0] DEADBAND_RST = 10'd50;
  localparam logic [WT_W-1:0] WEIGHT_RST   = 4'd3;
  localparam logic [MV_W-1:0] EMPTY_RST    = 13'd3000;
  localparam logic [MV_W-1:0] FULL_RST     = 13'd4200;

  // Configuration seen by the back end
  typedef struct packed {
    logic [DB_W-1:0] deadband_mv;
    logic [WT_W-1:0] new_weight_tenths;
    logic [MV_W-1:0] empty_mv;
    logic [MV_W-1:0] full_mv;
  } cfg_t;

endpackage

/* rtl/bvs_fifo.sv */
// Small register queue with full/empty flags.
// Depends on nothing; used between front, back and result ports.
module bvs_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/bvs_front.sv */
// Front end: takes ADC samples and sums them per block.
// Depends on bvs_pkg; hands finished block sums to the sum queue.
module bvs_front #(
  parameter int SAMPLES_PER_RESULT = 10,
  parameter int SUM_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [bvs_pkg::ADC_W-1:0] adc_sample,
  output logic                      full,
  output logic                      sum_push,
  output logic [SUM_W-1:0]          sum_data,
  input  logic                      sum_full
);
  import bvs_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sum_next;
  logic             last;
  logic             take;

  assign last     = (sample_count == LAST);
  assign full     = last && sum_full;
  assign take     = push && !full;
  assign sum_next = sample_sum + SUM_W'(adc_sample);
  assign sum_push = take && last;
  assign sum_data = sum_next;

  // Block accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sample_sum   <= '0;
    end else if (take) begin
      if (last) begin
        sample_count <= '0;
        sample_sum   <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        sample_sum   <= sum_next;
      end
    end
  end

endmodule

/* rtl/bvs_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; carries out the percent division of the back end.
module bvs_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(NUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in as numerator bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/bvs_back.sv */
// Back end: converts block sums to millivolts, smooths, maps to percent.
// Depends on bvs_pkg and bvs_div.
module bvs_back #(
  parameter int SAMPLES_PER_RESULT = 10,
  parameter int SUM_W = 16,
  parameter int NUM_W = 29,
  parameter int DEN_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bvs_pkg::cfg_t             cfg,
  input  logic [SUM_W-1:0]          sum_data,
  input  logic                      sum_empty,
  output logic                      sum_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output logic [bvs_pkg::MV_W-1:0]  res_mv,
  output logic [bvs_pkg::PCT_W-1:0] res_pct
);
  import bvs_pkg::*;

  // Millivolt conversion sum * 6600 / (4095 * N) as multiply and shift;
  // exact for every block sum since (4095 * N)^2 < 2^(2 * SUM_W)
  localparam longint unsigned BLOCK_DEN =
      longint'(ADC_MAX) * longint'(SAMPLES_PER_RESULT);
  localparam int MV_SHIFT  = 2 * SUM_W;
  localparam int MV_RCP_W  = SUM_W + MV_W + 1;
  localparam int MV_PROD_W = SUM_W + MV_RCP_W;
  localparam longint unsigned MV_RCP_VAL =
      ((longint'(FULL_SCALE_MV) << MV_SHIFT) + BLOCK_DEN - 1) / BLOCK_DEN;
  localparam logic [MV_RCP_W-1:0] MV_RCP = MV_RCP_W'(MV_RCP_VAL);

  // Divide by ten of the weighted mix, exact for any 18-bit mix
  localparam int MIX_W      = 18;
  localparam int MIX_SHIFT  = MIX_W + WT_W;
  localparam int MIX_RCP_W  = MIX_W + 1;
  localparam int MIX_PROD_W = MIX_W + MIX_RCP_W;
  localparam logic [MIX_RCP_W-1:0] MIX_RCP =
      MIX_RCP_W'(((longint'(1) << MIX_SHIFT) + WT_FULL - 1) / WT_FULL);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_PCT  = 3'd5;
  localparam logic [2:0] S_DIV3 = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state;
  logic [SUM_W-1:0] sum_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic [MV_W-1:0]  new_mv;
  logic [MV_W-1:0]  smoothed;
  logic [PCT_W-1:0] pct;

  logic [MV_W-1:0]       diff;
  logic [WT_W-1:0]       w;
  logic [WT_W-1:0]       w_old;
  logic [MIX_W-1:0]      mix;
  logic [MV_W-1:0]       above;
  logic [MV_W-1:0]       span;
  logic [MV_PROD_W-1:0]  mv_prod;
  logic [MIX_PROD_W-1:0] mix_prod;

  bvs_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_r),
    .den  (den_r),
    .done (div_done),
    .quo  (quo)
  );

  // Smoothing terms
  always_comb begin
    diff  = (new_mv > smoothed) ? new_mv - smoothed : smoothed - new_mv;
    w     = (cfg.new_weight_tenths > WT_W'(WT_FULL)) ? WT_W'(WT_FULL)
                                                      : cfg.new_weight_tenths;
    w_old = WT_W'(WT_FULL) - w;
    mix   = MIX_W'(w_old) * MIX_W'(smoothed) + MIX_W'(w) * MIX_W'(new_mv);
    above = smoothed - cfg.empty_mv;
    span  = cfg.full_mv - cfg.empty_mv;
  end

  // Reciprocal products
  assign mv_prod  = MV_PROD_W'(sum_r) * MV_PROD_W'(MV_RCP);
  assign mix_prod = MIX_PROD_W'(num_r[MIX_W-1:0]) * MIX_PROD_W'(MIX_RCP);

  assign sum_pop  = (state == S_IDLE) && !sum_empty && !res_full;
  assign res_push = (state == S_DONE);
  assign res_mv   = smoothed;
  assign res_pct  = pct;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      smoothed  <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sum_pop) begin
            sum_r <= sum_data;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          new_mv <= mv_prod[MV_SHIFT +: MV_W];
          state  <= S_MIX;
        end
        S_MIX: begin
          if (diff >= MV_W'(cfg.deadband_mv)) begin
            num_r <= NUM_W'(mix);
            state <= S_DIV2;
          end else begin
            state <= S_PCT;
          end
        end
        // Mix divided by ten
        S_DIV2: begin
          smoothed <= mix_prod[MIX_SHIFT +: MV_W];
          state    <= S_PCT;
        end
        S_PCT: begin
          if (cfg.full_mv <= cfg.empty_mv || smoothed <= cfg.empty_mv) begin
            pct   <= '0;
            state <= S_DONE;
          end else begin
            num_r     <= NUM_W'(above) * NUM_W'(PCT_FULL);
            den_r     <= DEN_W'(span);
            div_start <= 1'b1;
            state     <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (div_done) begin
            pct   <= (quo > NUM_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : quo[PCT_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_pct <= PCT_W'(PCT_FULL)))
    else $error("percent above full scale");

  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_mv <= MV_W'(FULL_SCALE_MV)))
    else $error("voltage above full scale");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    sum_pop |=> (state == S_MUL))
    else $error("sum taken without starting conversion");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV3))
    else $error("divider finished outside the percent step");
`endif

endmodule

/* rtl/battery_voltage_smoother.sv */
// Battery voltage smoother: top level with configuration registers and queues.
// Depends on bvs_pkg, bvs_front, bvs_fifo, bvs_back.
//
// Accepts one 12-bit ADC sample per cycle while full is low and emits one
// result (smoothed millivolts and charge percent) per block of
// SAMPLES_PER_RESULT samples. The back end turns a block sum into millivolts
// and divides the weighted mix by ten through reciprocal multiplication, and
// runs the percent division on a bit-serial divider of NUM_W =
// clog2(4095*N+1) + 13 steps (29 for N = 10). The back end takes one block
// sum at a time and pops the next only after its result has entered the
// result queue, so for N = 10 a steady back-to-back sample stream stalls the
// input; two-entry queues sit between the sample accumulator and the back end
// and in front of the result ports, and full rises only when a block ends with
// the sum queue full. Configuration writes take effect on the next clock.
module battery_voltage_smoother #(
  parameter int SAMPLES_PER_RESULT = bvs_pkg::SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [bvs_pkg::ADC_W-1:0]   adc_sample,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output logic [bvs_pkg::MV_W-1:0]    voltage_mv,
  output logic [bvs_pkg::PCT_W-1:0]   battery_percent,
  input  logic                        cfg_we,
  input  logic [bvs_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [bvs_pkg::CFG_W-1:0]   cfg_data
);
  import bvs_pkg::*;

  localparam int SUM_W  = $clog2(ADC_MAX * SAMPLES_PER_RESULT + 1);
  localparam int NUM_W  = SUM_W + MV_W;
  localparam int DEN_W  = (SUM_W > MV_W) ? SUM_W : MV_W;
  localparam int RES_W  = MV_W + PCT_W;

  cfg_t             cfg;
  logic             sum_push;
  logic [SUM_W-1:0] sum_wdata;
  logic [SUM_W-1:0] sum_rdata;
  logic             sum_full;
  logic             sum_empty;
  logic             sum_pop;
  logic             res_push;
  logic             res_full;
  logic [MV_W-1:0]  res_mv;
  logic [PCT_W-1:0] res_pct;
  logic [RES_W-1:0] res_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_mv       <= DEADBAND_RST;
      cfg.new_weight_tenths <= WEIGHT_RST;
      cfg.empty_mv          <= EMPTY_RST;
      cfg.full_mv           <= FULL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEADBAND: cfg.deadband_mv       <= cfg_data[DB_W-1:0];
        REG_WEIGHT:   cfg.new_weight_tenths <= cfg_data[WT_W-1:0];
        REG_EMPTY:    cfg.empty_mv          <= cfg_data[MV_W-1:0];
        REG_FULL:     cfg.full_mv           <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bvs_front #(
    .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT),
    .SUM_W             (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .adc_sample(adc_sample),
    .full      (full),
    .sum_push  (sum_push),
    .sum_data  (sum_wdata),
    .sum_full  (sum_full)
  );

  bvs_fifo #(
    .WIDTH(SUM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_sum_q (
    .clk  (clk),
    .rst  (rst),
    .push (sum_push),
    .wdata(sum_wdata),
    .pop  (sum_pop),
    .rdata(sum_rdata),
    .full (sum_full),
    .empty(sum_empty)
  );

  bvs_back #(
    .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT),
    .SUM_W             (SUM_W),
    .NUM_W             (NUM_W),
    .DEN_W             (DEN_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .sum_data (sum_rdata),
    .sum_empty(sum_empty),
    .sum_pop  (sum_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_mv   (res_mv),
    .res_pct  (res_pct)
  );

  bvs_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata({res_mv, res_pct}),
    .pop  (pop),
    .rdata(res_rdata),
    .full (res_full),
    .empty(empty)
  );

  assign voltage_mv      = res_rdata[RES_W-1:PCT_W];
  assign battery_percent = res_rdata[PCT_W-1:0];

endmodule

/* verif/tb.sv */
// Self-checking testbench for battery_voltage_smoother.
// Depends on bvs_pkg and the battery_voltage_smoother RTL; no other files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvs_pkg::*;

  localparam int BLOCK_LEN     = SAMPLES_DEF;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BLOCKS  = 19;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 1500;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [PCT_W-1:0] battery_percent;
  } battery_reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [ADC_W-1:0]   adc_sample = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic [MV_W-1:0]    voltage_mv;
  logic [PCT_W-1:0]   battery_percent;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Predictor state and its copy of the registers
  cfg_t        shadow_cfg;
  int unsigned block_sum;
  int unsigned block_count;
  int unsigned smoothed;

  logic [ADC_W-1:0] pending_samples[$];
  battery_reading_t expected_readings[$];
  battery_reading_t head_reading;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          failures = 0;
  int          sample_level = 2048;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        pressure_req = 1'b0;
  logic        hold_armed = 1'b0;

  battery_voltage_smoother #(
    .SAMPLES_PER_RESULT(BLOCK_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .adc_sample(adc_sample),
    .full(full),
    .empty(empty),
    .pop(pop),
    .voltage_mv(voltage_mv),
    .battery_percent(battery_percent),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Accumulate one accepted sample; at block end, queue the expected reading
  task automatic absorb_sample(input logic [ADC_W-1:0] s);
    int unsigned new_mv;
    int unsigned diff;
    int unsigned w;
    int unsigned pct;
    battery_reading_t r;
    block_sum += s;
    block_count++;
    if (block_count < BLOCK_LEN) return;
    new_mv = (block_sum * FULL_SCALE_MV) / (ADC_MAX * BLOCK_LEN);
    block_sum = 0;
    block_count = 0;
    diff = (new_mv > smoothed) ? new_mv - smoothed : smoothed - new_mv;
    if (diff >= shadow_cfg.deadband_mv) begin
      w = (shadow_cfg.new_weight_tenths > WT_FULL) ? WT_FULL : shadow_cfg.new_weight_tenths;
      smoothed = ((WT_FULL - w) * smoothed + w * new_mv) / WT_FULL;
    end
    // Charge percent: zero for a degenerate span or at/below empty
    if (shadow_cfg.full_mv <= shadow_cfg.empty_mv || smoothed <= shadow_cfg.empty_mv) begin
      pct = 0;
    end else begin
      pct = ((smoothed - shadow_cfg.empty_mv) * PCT_FULL) /
            (shadow_cfg.full_mv - shadow_cfg.empty_mv);
      if (pct > PCT_FULL) pct = PCT_FULL;
    end
    r.voltage_mv = smoothed[MV_W-1:0];
    r.battery_percent = pct[PCT_W-1:0];
    expected_readings.push_back(r);
  endtask

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) absorb_sample(adc_sample);
      if (!push || !full) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          adc_sample <= pending_samples.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b0;
    end else if (pressure_req && !hold_armed) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_readings.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("unexpected transfer: voltage_mv=%0d battery_percent=%0d",
                     voltage_mv, battery_percent);
          failures++;
        end else begin
          head_reading = expected_readings.pop_front();
          if (voltage_mv !== head_reading.voltage_mv ||
              battery_percent !== head_reading.battery_percent) begin
            if (failures < MAX_REPORTS)
              $display("mismatch: expected %0d mV %0d%%, got %0d mV %0d%%",
                       head_reading.voltage_mv, head_reading.battery_percent,
                       voltage_mv, battery_percent);
            failures++;
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("battery_voltage_smoother test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      REG_DEADBAND: shadow_cfg.deadband_mv = val[DB_W-1:0];
      REG_WEIGHT:   shadow_cfg.new_weight_tenths = val[WT_W-1:0];
      REG_EMPTY:    shadow_cfg.empty_mv = val[MV_W-1:0];
      REG_FULL:     shadow_cfg.full_mv = val[MV_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int db, input int wt, input int lo, input int hi);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_WEIGHT, wt);
    write_reg(REG_EMPTY, lo);
    write_reg(REG_FULL, hi);
  endtask

  // Blocks of samples: mostly a drifting level with small noise, some steps,
  // some blocks held at either rail and some pure noise
  task automatic queue_blocks(input int blocks);
    int style;
    int noise;
    int s;
    for (int b = 0; b < blocks; b++) begin
      style = $urandom_range(9);
      if (style == 0) begin
        sample_level = $urandom_range(1) ? 4095 : 0;
      end else if (style <= 2) begin
        sample_level = $urandom_range(4095);
      end else begin
        sample_level = sample_level + int'($urandom_range(40)) - 20;
        if (sample_level < 0) sample_level = 0;
        else if (sample_level > 4095) sample_level = 4095;
      end
      noise = (style == 0) ? 0 : int'($urandom_range(16));
      for (int i = 0; i < BLOCK_LEN; i++) begin
        if (style == 9) s = $urandom_range(4095);
        else s = sample_level + int'($urandom_range(2 * noise)) - noise;
        if (s < 0) s = 0;
        else if (s > 4095) s = 4095;
        pending_samples.push_back(s[ADC_W-1:0]);
      end
    end
  endtask

  // Wait for every sample and reading to transfer, then let the back end settle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || push || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int lo;
    int hi;
    shadow_cfg.deadband_mv = DEADBAND_RST;
    shadow_cfg.new_weight_tenths = WEIGHT_RST;
    shadow_cfg.empty_mv = EMPTY_RST;
    shadow_cfg.full_mv = FULL_RST;
    block_sum = 0;
    block_count = 0;
    smoothed = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset configuration, full-scale block, then alternating bits
    for (int i = 0; i < BLOCK_LEN; i++) pending_samples.push_back(12'hFFF);
    for (int i = 0; i < BLOCK_LEN; i++)
      pending_samples.push_back((i % 2) ? 12'h555 : 12'hAAA);
    for (int i = 0; i < 4; i++) pending_samples.push_back(12'h000);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(0, 10, 0, 6600);       // widest span, full weight
        1: set_config(50, 3, 3000, 4200);    // power-on values
        2: set_config(1000, 0, 6600, 0);     // full below empty, max band
        3: set_config(20, 15, 3500, 3500);   // weight saturates, empty == full
        4: set_config(5, 12, 1000, 5000);
        default: begin
          lo = $urandom_range(6600);
          hi = ($urandom_range(3) == 0) ? int'($urandom_range(6600))
                                        : int'($urandom_range(6600, lo));
          set_config($urandom_range(1000), $urandom_range(15), lo, hi);
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct <= 37; recv_stall_pct <= 37; end
      endcase
      if (ph == 0) pressure_req <= 1'b1;
      queue_blocks(PHASE_BLOCKS);
      wait_drained();
    end

    if (failures == 0) begin
      $display("battery_voltage_smoother test passed");
    end else begin
      $display("battery_voltage_smoother test failed");
    end
    $finish;
  end

endmodule
